// ===== hdl/rkit_pkg.sv =====
// ----------------------------------------------------------------------------
// rkit_pkg
// Shared widths, operation and status codes, and controller/datapath types
// for the reference-counted key intern table.
// ----------------------------------------------------------------------------
package rkit_pkg;

    localparam int OP_W      = 2;
    localparam int CRC_W     = 32;
    localparam int LEN_W     = 16;
    localparam int HANDLE_W  = 8;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 16;
    localparam int LIVE_W    = 9;

    // A handle is 8 bits wide, so no more than this many slots are addressable.
    localparam int HANDLE_SPACE     = 2 ** HANDLE_W;
    localparam int DEF_TABLE_SLOTS  = 256;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 32;

    localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD_REF  = 2'd1;
    localparam logic [OP_W-1:0] OP_REM_REF  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADHANDLE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FREED     = 3'd5;

    typedef struct packed {
        logic [CRC_W-1:0]   crc;
        logic [LEN_W-1:0]   len;
        logic [COUNT_W-1:0] refs;
    } t_entry;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                empty;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // input transfer: latch the item, restart the scan
        logic scan_run;   // step the key scan
        logic hnd_read;   // read the entry named by the handle
        logic do_update;  // count update of the hit or handle entry
        logic do_alloc;   // allocate the first free slot
        logic do_full;    // report a full table
        logic do_bad;     // report an invalid handle
        logic out_load;   // move the finished result to the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic key_op;      // captured item is a register
        logic handle_ok;   // add/remove with a present, in-range, live handle
        logic hit;         // key matched in the compare stage
        logic scan_done;   // last slot compared without a match
        logic free_found;  // a free slot was seen during the scan
        logic out_free;    // output register can take a result this cycle
    } t_sts;

endpackage

// ===== hdl/rkit_ctrl.sv =====
// ----------------------------------------------------------------------------
// rkit_ctrl
// Sequencer for the intern table: dispatches an item, runs the key scan and
// the count update, and hands the result to the output register.
// ----------------------------------------------------------------------------
module rkit_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rkit_pkg::t_sts i_sts,
    output rkit_pkg::t_cmd o_cmd
);
    import rkit_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MISS = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.key_op) begin
                    n_state = S_SCAN;
                end else if (i_sts.handle_ok) begin
                    o_cmd.hnd_read = 1'b1;
                    n_state        = S_UPD;
                end else begin
                    o_cmd.do_bad = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_UPD;
                end else if (i_sts.scan_done) begin
                    n_state = S_MISS;
                end
            end
            S_MISS: begin
                // The free-slot marker, registered from the last compare, has settled in this state.
                if (i_sts.free_found) begin
                    o_cmd.do_alloc = 1'b1;
                end else begin
                    o_cmd.do_full = 1'b1;
                end
                n_state = S_OUT;
            end
            S_UPD: begin
                o_cmd.do_update = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/rkit_dp.sv =====
// ----------------------------------------------------------------------------
// rkit_dp
// Datapath of the intern table: entry memory, valid bits, live counter,
// pipelined key scan, count update and the output register.
// ----------------------------------------------------------------------------
module rkit_dp #(
    parameter int TABLE_SLOTS = rkit_pkg::DEF_TABLE_SLOTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [rkit_pkg::S_TDATA_W-1:0]  i_in_data,
    input  logic [rkit_pkg::S_TUSER_W-1:0]  i_in_user,
    output logic                            o_out_valid,
    output logic [rkit_pkg::M_TDATA_W-1:0]  o_out_data,
    input  logic                            i_out_ready,
    input  rkit_pkg::t_cmd                  i_cmd,
    output rkit_pkg::t_sts                  o_sts
);
    import rkit_pkg::*;

    localparam int USABLE_SLOTS = (TABLE_SLOTS < HANDLE_SPACE) ? TABLE_SLOTS : HANDLE_SPACE;
    localparam int SLOT_W       = $clog2(USABLE_SLOTS);
    localparam logic [SLOT_W:0]   USABLE_CNT = (SLOT_W + 1)'(USABLE_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_IDX   = SLOT_W'(USABLE_SLOTS - 1);
    localparam logic [HANDLE_W:0] USABLE_H   = (HANDLE_W + 1)'(USABLE_SLOTS);

    // Captured item
    logic [OP_W-1:0]     r_op;
    logic [CRC_W-1:0]    r_crc;
    logic [LEN_W-1:0]    r_len;
    logic [HANDLE_W-1:0] r_hnd;
    logic                r_present;

    // Table storage
    t_entry                r_mem [USABLE_SLOTS];
    t_entry                r_rd_data;
    logic [USABLE_SLOTS-1:0] r_valid;
    logic [LIVE_W-1:0]     r_live;

    // Scan pipeline
    logic [SLOT_W:0]   r_idx;
    logic              r_cmp_act;
    logic              r_cmp_vld;
    logic [SLOT_W-1:0] r_cmp_idx;
    logic              r_free_found;
    logic [SLOT_W-1:0] r_free_idx;

    t_result r_res;
    t_result n_res;
    t_result r_out;
    logic    r_out_vld;

    logic              hit;
    logic              scan_issue;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              hnd_in_range;
    logic [SLOT_W-1:0] hnd_idx;
    logic [SLOT_W-1:0] upd_idx;
    logic [COUNT_W-1:0] cnt;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    t_entry            wr_data;
    logic              set_valid;
    logic              clr_valid;

    assign hnd_idx      = r_hnd[SLOT_W-1:0];
    assign hnd_in_range = ({1'b0, r_hnd} < USABLE_H);

    assign hit = r_cmp_act && r_cmp_vld &&
                 (r_rd_data.crc == r_crc) && (r_rd_data.len == r_len);

    // The read port stops once a match is seen so the hit entry stays in r_rd_data.
    assign scan_issue = i_cmd.scan_run && !hit && (r_idx < USABLE_CNT);
    assign rd_en      = scan_issue || i_cmd.hnd_read;
    assign rd_addr    = i_cmd.hnd_read ? hnd_idx : r_idx[SLOT_W-1:0];

    assign o_sts.key_op     = (r_op == OP_REGISTER);
    assign o_sts.handle_ok  = ((r_op == OP_ADD_REF) || (r_op == OP_REM_REF)) && r_present &&
                              hnd_in_range && r_valid[hnd_idx];
    assign o_sts.hit        = hit;
    assign o_sts.scan_done  = r_cmp_act && !hit && (r_cmp_idx == LAST_IDX);
    assign o_sts.free_found = r_free_found;
    assign o_sts.out_free   = !r_out_vld || i_out_ready;

    assign upd_idx = (r_op == OP_REGISTER) ? r_cmp_idx : hnd_idx;
    assign cnt     = r_rd_data.refs;

    always_comb begin
        n_res     = r_res;
        wr_en     = 1'b0;
        wr_addr   = upd_idx;
        wr_data   = r_rd_data;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        priority if (i_cmd.do_update) begin
            n_res.handle = (r_op == OP_REGISTER) ? HANDLE_W'(r_cmp_idx) : r_hnd;
            n_res.empty  = 1'b0;
            if (r_op == OP_REM_REF) begin
                if (cnt <= COUNT_W'(1)) begin
                    clr_valid    = 1'b1;
                    n_res.status = ST_FREED;
                    n_res.count  = '0;
                    n_res.empty  = (r_live <= LIVE_W'(1));
                end else begin
                    wr_en        = 1'b1;
                    wr_data.refs = cnt - COUNT_W'(1);
                    n_res.status = ST_OK;
                    n_res.count  = cnt - COUNT_W'(1);
                end
            end else if (cnt == '1) begin
                n_res.status = ST_OVERFLOW;
                n_res.count  = '1;
            end else begin
                wr_en        = 1'b1;
                wr_data.refs = cnt + COUNT_W'(1);
                n_res.status = ST_OK;
                n_res.count  = cnt + COUNT_W'(1);
            end
        end else if (i_cmd.do_alloc) begin
            wr_en        = 1'b1;
            wr_addr      = r_free_idx;
            wr_data.crc  = r_crc;
            wr_data.len  = r_len;
            wr_data.refs = COUNT_W'(1);
            set_valid    = 1'b1;
            n_res.handle = HANDLE_W'(r_free_idx);
            n_res.status = ST_NEW;
            n_res.count  = COUNT_W'(1);
            n_res.empty  = 1'b0;
        end else if (i_cmd.do_full) begin
            n_res.handle = '0;
            n_res.status = ST_FULL;
            n_res.count  = '0;
            n_res.empty  = 1'b0;
        end else if (i_cmd.do_bad) begin
            n_res.handle = r_hnd;
            n_res.status = ST_BADHANDLE;
            n_res.count  = '0;
            n_res.empty  = 1'b0;
        end else begin
            n_res = r_res;
        end
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_crc     <= i_in_data[31:0];
            r_len     <= i_in_data[47:32];
            r_hnd     <= i_in_data[55:48];
            r_present <= i_in_data[56];
            r_op      <= i_in_user;
        end
        if (rd_en) begin
            r_cmp_vld <= r_valid[rd_addr];
            r_cmp_idx <= rd_addr;
        end
        if (r_cmp_act && !r_cmp_vld && !r_free_found) begin
            r_free_idx <= r_cmp_idx;
        end
        r_res <= n_res;
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_live       <= '0;
            r_idx        <= '0;
            r_cmp_act    <= 1'b0;
            r_free_found <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (set_valid) begin
                r_valid[wr_addr] <= 1'b1;
                r_live           <= r_live + LIVE_W'(1);
            end else if (clr_valid) begin
                r_valid[wr_addr] <= 1'b0;
                r_live           <= (r_live != '0) ? r_live - LIVE_W'(1) : r_live;
            end

            if (i_cmd.capture) begin
                r_idx        <= '0;
                r_cmp_act    <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (scan_issue) begin
                    r_idx <= r_idx + (SLOT_W + 1)'(1);
                end
                r_cmp_act <= scan_issue;
                if (r_cmp_act && !r_cmp_vld) begin
                    r_free_found <= 1'b1;
                end
            end

            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = {4'b0000, r_out.empty, r_out.count, r_out.status, r_out.handle};

endmodule

// ===== hdl/refcounted_key_intern_table_core.sv =====
// ----------------------------------------------------------------------------
// refcounted_key_intern_table_core
// Interning table keyed by (CRC32, length) with one reference count per slot.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_axis channel, one result per item leaves on m_axis.
//   s_axis_tuser carries the opcode (register, add reference, remove
//   reference); s_axis_tdata carries key and handle fields.
//   The block works on one item at a time. A register item scans the slots
//   one per cycle through the registered read port of the entry memory; a
//   miss compares every slot, then allocates or reports a full table, and a
//   hit stops at the match. Add and remove items read the named entry and
//   adjust its count; an invalid handle or opcode goes straight to the
//   result. The input reopens as the result is loaded into the output register.
//   The output register decouples the sides: the next item is accepted while
//   a result waits for m_axis_tready. If the receiver stalls long enough,
//   the finished result of the following item waits inside the block and
//   s_axis_tready stays low until the output register frees.
//   Reset clears all valid bits at once and the live count, so the table is
//   empty and ready on the first cycle after reset; no clearing pass is run.
// ----------------------------------------------------------------------------
module refcounted_key_intern_table_core #(
    parameter int TABLE_SLOTS = rkit_pkg::DEF_TABLE_SLOTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // key_crc [31:0], key_length [47:32], slot_handle [55:48],
    // handle_present [56], zero [63:57]
    input  logic [rkit_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // opcode [1:0]
    input  logic [rkit_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // result_handle [7:0], status [10:8], ref_count [26:11],
    // now_empty [27], zero [31:28]
    output logic [rkit_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import rkit_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rkit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rkit_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_out_ready (m_axis_tready),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

`ifndef SYNTHESIS
    // One item at a time: a transfer closes the input until its result is done.
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

    // A result must never overwrite one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten while stalled");

    // At most one way of finishing an item is chosen at a time.
    a_one_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.do_update, cmd.do_alloc, cmd.do_full, cmd.do_bad}))
        else $error("more than one result source in a cycle");
`endif

endmodule

// ===== dv/refcounted_key_intern_table_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_key_intern_table_core_tb
// Self-checking bench for the key intern table. A queue of operations feeds a
// stream driver, and a shadow copy of the table predicts every reply. A
// monitor compares each reply, field by field, with the oldest prediction.
// The operations run in this order: directed corner cases, a table fill up
// to the full condition, and a burst of references stacked on one entry.
// Random traffic is mixed in under changing idle patterns on both sides.
// ----------------------------------------------------------------------------
module refcounted_key_intern_table_core_tb;

    import rkit_pkg::*;

    localparam int SLOTS = (DEF_TABLE_SLOTS < HANDLE_SPACE) ? DEF_TABLE_SLOTS : HANDLE_SPACE;
    localparam logic [OP_W-1:0]    OP_UNKNOWN  = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_TOP   = '1;
    localparam int ST_LSB       = HANDLE_W;
    localparam int CNT_LSB      = HANDLE_W + STATUS_W;
    localparam int EMPTY_BIT    = CNT_LSB + COUNT_W;
    localparam int PAD_W        = S_TDATA_W - CRC_W - LEN_W - HANDLE_W - 1;
    localparam int BACKLOG_MAX  = 4;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int RANDOM_OPS   = 1050;
    localparam int HOT_ADDS     = 8;
    localparam logic [CRC_W-1:0] HOT_CRC = 32'h0F0F_A5A5;
    localparam logic [LEN_W-1:0] HOT_LEN = 16'h0100;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [CRC_W-1:0]    crc;
        logic [LEN_W-1:0]    len;
        logic [HANDLE_W-1:0] handle;
        logic                present;
        bit                  hold;       // wait for all replies before offering
        int                  gap_pct;
        int                  stall_pct;
    } t_intern_op;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // key_crc, key_length, slot_handle, handle_present, zero padding
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    // opcode
    logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // result_handle, status, ref_count, now_empty, zero padding
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    // Shadow copy of the table.
    bit                    mir_valid [SLOTS];
    bit [CRC_W-1:0]        mir_crc   [SLOTS];
    bit [LEN_W-1:0]        mir_len   [SLOTS];
    bit [COUNT_W-1:0]      mir_refs  [SLOTS];
    int                    mir_live = 0;

    t_intern_op            op_backlog [$];
    t_intern_op            in_flight;
    t_result               owed_replies [$];

    int                    plan_gap   = 0;
    int                    plan_stall = 0;
    int                    stall_pct  = 0;
    int                    ops_queued = 0;
    int                    ops_taken  = 0;
    int                    replies_checked = 0;
    int                    mismatch_count  = 0;
    int                    empties_seen    = 0;
    int                    status_tally [8];
    int                    cycle_count = 0;

    refcounted_key_intern_table_core #(
        .TABLE_SLOTS (DEF_TABLE_SLOTS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Applies one operation to the shadow table and returns the reply it owes.
    function automatic t_result intern_reply(t_intern_op t);
        t_result r;
        int      free_slot;
        int      s;
        r         = '0;
        free_slot = -1;
        if (t.op == OP_REGISTER) begin
            for (s = 0; s < SLOTS; s++) begin
                if (mir_valid[s]) begin
                    if (mir_crc[s] == t.crc && mir_len[s] == t.len) begin
                        r.handle = HANDLE_W'(s);
                        if (mir_refs[s] == COUNT_TOP) begin
                            r.status = ST_OVERFLOW;
                            r.count  = COUNT_TOP;
                        end else begin
                            mir_refs[s] = mir_refs[s] + COUNT_W'(1);
                            r.status    = ST_OK;
                            r.count     = mir_refs[s];
                        end
                        return r;
                    end
                end else if (free_slot < 0) begin
                    free_slot = s;
                end
            end
            if (free_slot < 0) begin
                r.status = ST_FULL;
                return r;
            end
            mir_valid[free_slot] = 1'b1;
            mir_crc[free_slot]   = t.crc;
            mir_len[free_slot]   = t.len;
            mir_refs[free_slot]  = COUNT_W'(1);
            mir_live++;
            r.handle = HANDLE_W'(free_slot);
            r.status = ST_NEW;
            r.count  = COUNT_W'(1);
            return r;
        end

        r.handle = t.handle;
        if (t.op == OP_UNKNOWN || !t.present || int'(t.handle) >= SLOTS ||
            !mir_valid[t.handle]) begin
            r.status = ST_BADHANDLE;
        end else if (t.op == OP_ADD_REF) begin
            if (mir_refs[t.handle] == COUNT_TOP) begin
                r.status = ST_OVERFLOW;
                r.count  = COUNT_TOP;
            end else begin
                mir_refs[t.handle] = mir_refs[t.handle] + COUNT_W'(1);
                r.status           = ST_OK;
                r.count            = mir_refs[t.handle];
            end
        end else if (mir_refs[t.handle] <= COUNT_W'(1)) begin
            // Last reference gone: the slot returns to the free pool.
            mir_refs[t.handle]  = '0;
            mir_valid[t.handle] = 1'b0;
            if (mir_live > 0) mir_live--;
            r.status = ST_FREED;
            r.empty  = (mir_live == 0);
        end else begin
            mir_refs[t.handle] = mir_refs[t.handle] - COUNT_W'(1);
            r.status           = ST_OK;
            r.count            = mir_refs[t.handle];
        end
        return r;
    endfunction

    task automatic report_bad(input string what, input t_result want, input t_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] %s: expected handle=%0d status=%0d count=%0d empty=%0b",
                     $time, what, want.handle, want.status, want.count, want.empty);
            $display("[%0t] %s:   actual handle=%0d status=%0d count=%0d empty=%0b",
                     $time, what, got.handle, got.status, got.count, got.empty);
        end
    endtask

    task automatic queue_op(input logic [OP_W-1:0] op, input logic [CRC_W-1:0] crc,
                            input logic [LEN_W-1:0] len, input logic [HANDLE_W-1:0] handle,
                            input logic present, input bit hold);
        t_intern_op item;
        item.op        = op;
        item.crc       = crc;
        item.len       = len;
        item.handle    = handle;
        item.present   = present;
        item.hold      = hold;
        item.gap_pct   = plan_gap;
        item.stall_pct = plan_stall;
        while (op_backlog.size() >= BACKLOG_MAX) @(posedge i_clk);
        op_backlog.insert(op_backlog.size(), item);
        ops_queued++;
    endtask

    task automatic wait_idle();
        while (ops_taken != ops_queued || owed_replies.size() != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic on live entries, picked from the shadow table.
    // The shadow may trail the queue by a few operations; a stale pick simply
    // turns into an invalid-handle case.
    task automatic queue_random_op(input bit hold);
        int               live_slots [$];
        int               dice;
        int               s;
        logic [CRC_W-1:0] crc;
        logic [LEN_W-1:0] len;
        for (s = 0; s < SLOTS; s++) begin
            if (mir_valid[s]) live_slots.insert(live_slots.size(), s);
        end
        dice = $urandom_range(0, 99);
        if (live_slots.size() == 0 && dice < 88) begin
            dice = 30;
        end else if (live_slots.size() > 40 && dice >= 20 && dice < 34) begin
            dice = 0;
        end
        s = (live_slots.size() != 0) ? live_slots[$urandom_range(0, live_slots.size() - 1)] : 0;
        if (dice < 20) begin
            queue_op(OP_REGISTER, mir_crc[s], mir_len[s], HANDLE_W'($urandom),
                     1'($urandom), hold);
        end else if (dice < 34) begin
            crc = $urandom;
            len = LEN_W'($urandom);
            if (dice < 27 && live_slots.size() != 0) begin
                // Same CRC as a live entry, length off by one bit.
                crc = mir_crc[s];
                len = mir_len[s] ^ (LEN_W'(1) << $urandom_range(0, LEN_W - 1));
            end
            queue_op(OP_REGISTER, crc, len, HANDLE_W'($urandom), 1'($urandom), hold);
        end else if (dice < 57) begin
            queue_op(OP_ADD_REF, $urandom, LEN_W'($urandom), HANDLE_W'(s), 1'b1, hold);
        end else if (dice < 88) begin
            queue_op(OP_REM_REF, $urandom, LEN_W'($urandom), HANDLE_W'(s), 1'b1, hold);
        end else begin
            queue_op(OP_W'($urandom_range(0, 3)), $urandom, LEN_W'($urandom),
                     HANDLE_W'($urandom), 1'($urandom), hold);
        end
    endtask

    always @(posedge i_clk) begin : op_driver
        logic       offer;
        t_intern_op nxt;
        offer = s_axis_tvalid;
        if (!i_rst_n) begin
            offer = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                owed_replies.insert(owed_replies.size(), intern_reply(in_flight));
                ops_taken++;
                offer = 1'b0;
            end
            if (!offer && op_backlog.size() != 0) begin
                nxt = op_backlog[0];
                if (!(nxt.hold && owed_replies.size() != 0) &&
                    $urandom_range(0, 99) >= nxt.gap_pct) begin
                    void'(op_backlog.pop_front());
                    in_flight    = nxt;
                    s_axis_tdata <= {{PAD_W{1'b0}}, nxt.present, nxt.handle, nxt.len, nxt.crc};
                    s_axis_tuser <= nxt.op;
                    stall_pct    <= nxt.stall_pct;
                    offer = 1'b1;
                end
            end
        end
        s_axis_tvalid <= offer;
    end

    always @(posedge i_clk) begin : reply_monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.handle = m_axis_tdata[HANDLE_W-1:0];
                got.status = m_axis_tdata[ST_LSB +: STATUS_W];
                got.count  = m_axis_tdata[CNT_LSB +: COUNT_W];
                got.empty  = m_axis_tdata[EMPTY_BIT];
                if (owed_replies.size() == 0) begin
                    want = '0;
                    report_bad("reply with nothing owed", want, got);
                end else begin
                    want = owed_replies.pop_front();
                    replies_checked++;
                    status_tally[want.status]++;
                    if (want.empty) empties_seen++;
                    if (got.handle !== want.handle || got.status !== want.status ||
                        got.count !== want.count || got.empty !== want.empty) begin
                        report_bad("reply mismatch", want, got);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("refcounted_key_intern_table_core regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int      hot;
        int      s;
        int      fill_slots [$];
        t_result none;
        none = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles lightly, receiver stalls half the time.
        plan_gap   = 20;
        plan_stall = 51;

        queue_op(OP_REM_REF,   '0, '0, 8'd0,   1'b1, 1'b0); // remove on an empty table
        queue_op(OP_REGISTER,  '0, '0, 8'd0,   1'b0, 1'b0); // all-zero key, new
        queue_op(OP_REGISTER,  '1, '1, 8'hFF,  1'b1, 1'b0); // all-ones key, new
        queue_op(OP_REGISTER,  '0, '0, 8'd0,   1'b0, 1'b0); // hit
        queue_op(OP_REGISTER,  '0, '1, 8'd0,   1'b0, 1'b0); // same CRC, other length
        queue_op(OP_REGISTER,  '1, '0, 8'd0,   1'b0, 1'b0); // same length, other CRC
        queue_op(OP_ADD_REF,   '0, '0, 8'd1,   1'b1, 1'b0);
        queue_op(OP_ADD_REF,   '0, '0, 8'd1,   1'b0, 1'b0); // null reference
        queue_op(OP_REM_REF,   '0, '0, 8'd1,   1'b0, 1'b0); // null reference
        queue_op(OP_ADD_REF,   '0, '0, 8'hFF,  1'b1, 1'b0); // slot never allocated
        queue_op(OP_REM_REF,   '0, '0, 8'd200, 1'b1, 1'b0); // slot never allocated
        queue_op(OP_UNKNOWN,   '0, '0, 8'd0,   1'b1, 1'b0); // undefined opcode, live handle
        queue_op(OP_REM_REF,   '0, '0, 8'd2,   1'b1, 1'b0); // frees slot 2
        queue_op(OP_REGISTER,  32'h1234_5678, 16'd5, 8'd0, 1'b0, 1'b0); // reuses slot 2
        queue_op(OP_REM_REF,   '0, '0, 8'd1,   1'b1, 1'b0);
        queue_op(OP_REM_REF,   '0, '0, 8'd1,   1'b1, 1'b0);
        queue_op(OP_ADD_REF,   '0, '0, 8'd1,   1'b1, 1'b0); // just freed
        queue_op(OP_REM_REF,   '0, '0, 8'd0,   1'b1, 1'b0);
        queue_op(OP_REM_REF,   '0, '0, 8'd0,   1'b1, 1'b0);
        queue_op(OP_REM_REF,   '0, '0, 8'd3,   1'b1, 1'b0);
        queue_op(OP_REM_REF,   '0, '0, 8'd2,   1'b1, 1'b0); // last entry: table empty
        queue_op(OP_UNKNOWN,   '1, '1, 8'hFF,  1'b0, 1'b0);

        repeat (RANDOM_OPS / 6) queue_random_op($urandom_range(0, 99) == 0);

        // Fill every free slot, then push past the limit.
        wait_idle();
        for (s = 0; s < SLOTS; s++) begin
            if (!mir_valid[s]) fill_slots.insert(fill_slots.size(), s);
        end
        foreach (fill_slots[i]) begin
            queue_op(OP_REGISTER, {16'hF11A, 8'h00, 8'(fill_slots[i])},
                     LEN_W'(fill_slots[i]), HANDLE_W'($urandom), 1'b1, 1'b0);
        end
        queue_op(OP_REGISTER, 32'hF11A_0100, 16'hABCD, '0, 1'b0, 1'b0);
        queue_op(OP_REGISTER, 32'hF11A_0101, 16'h1234, '1, 1'b1, 1'b0);
        wait_idle();
        // A hit on the last slot scans the whole table.
        queue_op(OP_REGISTER, mir_crc[SLOTS-1], mir_len[SLOTS-1], '0, 1'b0, 1'b0);
        foreach (fill_slots[i]) begin
            queue_op(OP_REM_REF, $urandom, LEN_W'($urandom), HANDLE_W'(fill_slots[i]),
                     1'b1, 1'b0);
        end

        repeat (RANDOM_OPS / 3 - RANDOM_OPS / 6) queue_random_op($urandom_range(0, 99) == 0);

        // Roles swap; the first operation waits until the block has drained.
        plan_gap   = 51;
        plan_stall = 20;
        queue_random_op(1'b1);
        repeat (RANDOM_OPS / 3 - 1) queue_random_op($urandom_range(0, 99) == 0);

        // No idling from here on: stack several references on one entry.
        plan_gap   = 0;
        plan_stall = 0;
        queue_op(OP_REGISTER, HOT_CRC, HOT_LEN, '0, 1'b0, 1'b0);
        wait_idle();
        hot = 0;
        for (s = 0; s < SLOTS; s++) begin
            if (mir_valid[s] && mir_crc[s] == HOT_CRC && mir_len[s] == HOT_LEN) hot = s;
        end
        repeat (HOT_ADDS) begin
            queue_op(OP_ADD_REF, $urandom, LEN_W'($urandom), HANDLE_W'(hot), 1'b1, 1'b0);
        end
        queue_op(OP_REGISTER, HOT_CRC, HOT_LEN, '0, 1'b0, 1'b0);    // hit on a shared entry
        queue_op(OP_REM_REF,  '0, '0, HANDLE_W'(hot), 1'b1, 1'b0);
        queue_op(OP_ADD_REF,  '0, '0, HANDLE_W'(hot), 1'b1, 1'b0);
        queue_op(OP_ADD_REF,  '0, '0, HANDLE_W'(hot), 1'b1, 1'b0);

        repeat (RANDOM_OPS - 2 * (RANDOM_OPS / 3)) queue_random_op($urandom_range(0, 99) == 0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (owed_replies.size() != 0) begin
            report_bad("reply never arrived", owed_replies.pop_front(), none);
        end

        $display("Sent %0d operations and checked %0d replies: ok %0d, new %0d, full %0d,",
                 ops_taken, replies_checked, status_tally[ST_OK], status_tally[ST_NEW],
                 status_tally[ST_FULL]);
        $display("bad handle %0d, overflow %0d, freed %0d (%0d emptied the table); %0d mismatches",
                 status_tally[ST_BADHANDLE], status_tally[ST_OVERFLOW],
                 status_tally[ST_FREED], empties_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("refcounted_key_intern_table_core regression: pass");
        end else begin
            $display("refcounted_key_intern_table_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== refcounted_key_intern_table_core.f =====
hdl/rkit_pkg.sv
hdl/rkit_ctrl.sv
hdl/rkit_dp.sv
hdl/refcounted_key_intern_table_core.sv
dv/refcounted_key_intern_table_core_tb.sv
